[rtl/lrr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limb radix repacker package
// Shared constants and types for the 29-bit limb / 32-bit word repacker.
// ----------------------------------------------------------------------------
package lrr_pkg;

   localparam int LIMB_BITS     = 29;
   localparam int WORD_BITS     = 32;
   localparam int MAX_OUT_WORDS = 64;
   localparam int OUT_WORDS_CAP = (MAX_OUT_WORDS < 64) ? MAX_OUT_WORDS : 64;

   localparam int ACC_W   = 63;
   localparam int KEEP_W  = 61;
   localparam int ABITS_W = 6;
   localparam int LEN_W   = 7;
   localparam int IDX_W   = 6;
   localparam int CSR_W   = 7;

   localparam logic DIR_PACK  = 1'b0;
   localparam logic DIR_SPLIT = 1'b1;

   localparam logic [LEN_W-1:0] OUT_LENGTH_RESET = LEN_W'(16);

   typedef enum logic [0:0] {
      CSR_DIRECTION  = 1'b0,
      CSR_OUT_LENGTH = 1'b1
   } csr_index_type;

endpackage

[rtl/limb_radix_repacker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limb radix repacker
// A request is absorbed into the accumulator at acceptance; its result words
// are then registered from the accumulator into the single output register.
// Results leave at one word per cycle while rsp_stall is low. New requests are
// stalled while words are still owed or a last request is still being closed.
// Synchronous active-high reset clears the control state but not the output
// word, index and flags; direction resets to 0 and the output length to 16.
// ----------------------------------------------------------------------------
module limb_radix_repacker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  lrr_pkg::csr_index_type        csr_index,
   input  logic [lrr_pkg::CSR_W-1:0]     csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lrr_pkg::WORD_BITS-1:0] req_in_word,
   input  logic                          req_in_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lrr_pkg::WORD_BITS-1:0] rsp_out_word,
   output logic [lrr_pkg::IDX_W-1:0]     rsp_out_index,
   output logic                          rsp_run_end,
   output logic                          rsp_final_word
);
   import lrr_pkg::*;

   logic                 dir_ff, dir_in;
   logic [LEN_W-1:0]     len_cfg_ff, len_cfg_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ABITS_W-1:0]   abits_ff, abits_in;
   logic [LEN_W-1:0]     we_ff, we_in;
   logic                 last_ff, last_in;
   logic                 run_ff, run_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] word_ff, word_in;
   logic [IDX_W-1:0]     index_ff, index_in;
   logic                 run_end_ff, run_end_in;
   logic                 final_ff, final_in;

   logic [LEN_W-1:0]     len_eff;
   logic [ABITS_W-1:0]   width;
   logic [ABITS_W-1:0]   inbits;
   logic [WORD_BITS-1:0] in_val;
   logic                 emit_cond;
   logic                 busy;
   logic                 req_accept;
   logic                 out_free;
   logic                 do_emit;
   logic [ACC_W-1:0]     acc_shift;
   logic [ABITS_W-1:0]   abits_sub;
   logic [LEN_W-1:0]     we_inc;
   logic                 emit_more;
   logic [WORD_BITS-1:0] emit_word;

   assign len_eff = (len_cfg_ff > LEN_W'(OUT_WORDS_CAP)) ? LEN_W'(OUT_WORDS_CAP) : len_cfg_ff;
   assign width   = (dir_ff == DIR_SPLIT) ? ABITS_W'(LIMB_BITS) : ABITS_W'(WORD_BITS);
   assign inbits  = (dir_ff == DIR_SPLIT) ? ABITS_W'(WORD_BITS) : ABITS_W'(LIMB_BITS);
   assign in_val  = (dir_ff == DIR_SPLIT) ? req_in_word
                                          : {{(WORD_BITS-LIMB_BITS){1'b0}},
                                             req_in_word[LIMB_BITS-1:0]};

   assign emit_cond  = run_ff && (we_ff < len_eff) && ((abits_ff >= width) || last_ff);
   assign busy       = emit_cond || last_ff;
   assign req_stall  = busy;
   assign req_accept = req_valid && !busy;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign do_emit    = emit_cond && out_free;

   assign acc_shift = (dir_ff == DIR_SPLIT) ? (acc_ff >> LIMB_BITS) : (acc_ff >> WORD_BITS);
   assign abits_sub = (abits_ff >= width) ? ABITS_W'(abits_ff - width) : '0;
   assign we_inc    = LEN_W'(we_ff + LEN_W'(1));
   assign emit_more = (we_inc < len_eff) && (last_ff || (abits_sub >= width));
   assign emit_word = (dir_ff == DIR_SPLIT)
                      ? {{(WORD_BITS-LIMB_BITS){1'b0}}, acc_ff[LIMB_BITS-1:0]}
                      : acc_ff[WORD_BITS-1:0];

   always_comb begin
      dir_in     = dir_ff;
      len_cfg_in = len_cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DIRECTION: begin
               dir_in = csr_wdata[0];
            end
            CSR_OUT_LENGTH: begin
               len_cfg_in = csr_wdata[LEN_W-1:0];
            end
            default: begin
               dir_in = dir_ff;
            end
         endcase
      end
   end

   always_comb begin
      acc_in   = acc_ff;
      abits_in = abits_ff;
      we_in    = we_ff;
      last_in  = last_ff;
      run_in   = run_ff;
      priority if (req_accept) begin
         last_in = req_in_last;
         run_in  = 1'b1;
         if (we_ff < len_eff) begin
            acc_in   = {{(ACC_W-KEEP_W){1'b0}}, acc_ff[KEEP_W-1:0]}
                       | (ACC_W'(in_val) << abits_ff[4:0]);
            abits_in = ABITS_W'(abits_ff + inbits);
         end else begin
            acc_in   = '0;
            abits_in = '0;
         end
      end else if (do_emit) begin
         acc_in   = acc_shift;
         abits_in = abits_sub;
         we_in    = we_inc;
         if (!emit_more) begin
            run_in = 1'b0;
         end
         if (we_inc >= len_eff) begin
            acc_in   = '0;
            abits_in = '0;
         end
         if (!emit_more && last_ff) begin
            acc_in   = '0;
            abits_in = '0;
            we_in    = '0;
            last_in  = 1'b0;
         end
      end else if (!emit_cond) begin
         run_in = 1'b0;
         if (last_ff) begin
            acc_in   = '0;
            abits_in = '0;
            we_in    = '0;
            last_in  = 1'b0;
         end
      end else begin
         run_in = run_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      word_in      = word_ff;
      index_in     = index_ff;
      run_end_in   = run_end_ff;
      final_in     = final_ff;
      if (do_emit) begin
         rsp_valid_in = 1'b1;
         word_in      = emit_word;
         index_in     = we_ff[IDX_W-1:0];
         run_end_in   = !emit_more;
         final_in     = (we_inc == len_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= DIR_PACK;
         len_cfg_ff   <= OUT_LENGTH_RESET;
         acc_ff       <= '0;
         abits_ff     <= '0;
         we_ff        <= '0;
         last_ff      <= 1'b0;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dir_ff       <= dir_in;
         len_cfg_ff   <= len_cfg_in;
         acc_ff       <= acc_in;
         abits_ff     <= abits_in;
         we_ff        <= we_in;
         last_ff      <= last_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      index_ff   <= index_in;
      run_end_ff <= run_end_in;
      final_ff   <= final_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_word   = word_ff;
   assign rsp_out_index  = index_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_final_word = final_ff;

   // The word that completes a conversion always ends the run of its request.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && final_ff |-> run_end_ff)
      else $error("final word without run end");

   // Limbs produced in the splitting direction stay below 2^29.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (dir_ff == DIR_SPLIT) |-> (word_ff[WORD_BITS-1:LIMB_BITS] == '0))
      else $error("limb wider than 29 bits");

   // The emitted word count never passes the largest conversion length.
   assert property (@(posedge clock) disable iff (reset)
      we_ff <= LEN_W'(OUT_WORDS_CAP))
      else $error("word count out of range");

   // A new request is never taken while a result is still being produced.
   assert property (@(posedge clock) disable iff (reset)
      do_emit |=> !$past(req_accept))
      else $error("request accepted during emission");

endmodule
